[hdl/tott_pkg.sv]
// ----------------------------------------------------------------------------
// tott_pkg
// Shared constants and payload type of the thermal overload trip time block.
// ----------------------------------------------------------------------------
`default_nettype none
package tott_pkg;

   localparam int FRAC_BITS = 16;
   localparam int AW        = 32 + FRAC_BITS;
   localparam int XW        = AW + 1;
   localparam int NW        = $clog2(XW);
   localparam int LW        = NW + 33;
   localparam int HW        = LW - 32;
   localparam int STEPS     = 32;

   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   localparam logic [1:0] REG_BASE_CURRENT  = 2'd0;
   localparam logic [1:0] REG_K_FACTOR      = 2'd1;
   localparam logic [1:0] REG_TIME_CONSTANT = 2'd2;

   typedef struct packed {
      logic [2:0][31:0]   m;
      logic [2:0][31:0]   f;
      logic [2:0][NW-1:0] n;
      logic               no_trip;
   } lg_type;

endpackage
`default_nettype wire

[hdl/tott_front.sv]
// ----------------------------------------------------------------------------
// tott_front
// Forms I*2^F, I*2^F - k*Ib and I*2^F + k*Ib, finds their exponents and
// normalizes them to Q1.31 mantissas.
// ----------------------------------------------------------------------------
`default_nettype none
module tott_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [31:0]           current,
   input  wire logic [31:0]           base_current,
   input  wire logic [19:0]           k_factor,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output tott_pkg::lg_type           out_data
);

   logic [2:0] v_ff;
   logic [3:0] rdy;

   logic [2:0][tott_pkg::XW-1:0] x1_ff;
   logic [2:0][tott_pkg::XW-1:0] x2_ff;
   logic [2:0][tott_pkg::NW-1:0] n2_ff;
   logic                         nt1_ff, nt2_ff;
   tott_pkg::lg_type             o_ff;

   logic [tott_pkg::AW-1:0]      a;
   logic [51:0]                  b;
   logic [2:0][tott_pkg::XW-1:0] x1_in;
   logic [2:0][tott_pkg::NW-1:0] n2_in;
   tott_pkg::lg_type             o_in;

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[2];
   assign out_data  = o_ff;

   always_comb begin
      rdy[3] = out_ready;
      for (int s = 2; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   always_comb begin
      a        = tott_pkg::AW'({current, {tott_pkg::FRAC_BITS{1'b0}}});
      b        = 52'(k_factor) * 52'(base_current);
      x1_in[0] = tott_pkg::XW'(a);
      x1_in[1] = tott_pkg::XW'(a) - tott_pkg::XW'(b);
      x1_in[2] = tott_pkg::XW'(a) + tott_pkg::XW'(b);
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         n2_in[j] = '0;
         for (int i = 0; i < tott_pkg::XW; i++) begin
            if (x1_ff[j][i]) begin
               n2_in[j] = tott_pkg::NW'(i);
            end
         end
      end
   end

   always_comb begin
      o_in.no_trip = nt2_ff;
      for (int j = 0; j < 3; j++) begin
         o_in.m[j] = 32'(({x2_ff[j], 31'b0}) >> n2_ff[j]);
         o_in.f[j] = '0;
         o_in.n[j] = n2_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x1_ff  <= x1_in;
         nt1_ff <= ({4'b0, a} <= b);
      end
      if (rdy[1]) begin
         x2_ff  <= x1_ff;
         n2_ff  <= n2_in;
         nt2_ff <= nt1_ff;
      end
      if (rdy[2]) begin
         o_ff <= o_in;
      end
   end

endmodule
`default_nettype wire

[hdl/tott_sq_cell.sv]
// ----------------------------------------------------------------------------
// tott_sq_cell
// One squaring step of the base-2 logarithm for all three mantissas.
// ----------------------------------------------------------------------------
`default_nettype none
module tott_sq_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire tott_pkg::lg_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output tott_pkg::lg_type      out_data
);

   logic             v_ff;
   tott_pkg::lg_type d_ff, d_in;
   logic [63:0]      sq;

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_data  = d_ff;

   always_comb begin
      d_in = in_data;
      sq   = '0;
      for (int j = 0; j < 3; j++) begin
         sq        = 64'(in_data.m[j]) * 64'(in_data.m[j]);
         d_in.f[j] = {in_data.f[j][30:0], sq[63]};
         d_in.m[j] = sq[63] ? sq[63:32] : sq[62:31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) d_ff <= d_in;
   end

endmodule
`default_nettype wire

[hdl/tott_back.sv]
// ----------------------------------------------------------------------------
// tott_back
// Combines the three logarithms, scales by ln 2 and tau, and saturates.
// ----------------------------------------------------------------------------
`default_nettype none
module tott_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire tott_pkg::lg_type in_data,
   input  wire logic [31:0]      time_constant,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [31:0]           trip_time,
   output logic                  no_trip
);

   localparam int HW = tott_pkg::HW;

   logic [4:0] v_ff;
   logic [5:0] rdy;
   logic [4:0] nt_ff;

   logic [tott_pkg::LW-1:0] l2_ff, l2_in;
   logic [63:0]             plo_ff, tlo_ff;
   logic [HW+31:0]          phi_ff, thi_ff;
   logic [tott_pkg::LW-1:0] ln_ff;
   logic [31:0]             t_ff;
   logic [tott_pkg::LW:0]   twice, sub;
   logic [HW+32:0]          tsum;

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[4];
   assign trip_time = t_ff;
   assign no_trip   = nt_ff[4];

   always_comb begin
      rdy[5] = out_ready;
      for (int s = 4; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   always_comb begin
      twice = {1'b0, in_data.n[0], in_data.f[0], 1'b0};
      sub   = (tott_pkg::LW+1)'({in_data.n[1], in_data.f[1]})
            + (tott_pkg::LW+1)'({in_data.n[2], in_data.f[2]});
      l2_in = (sub >= twice) ? '0 : tott_pkg::LW'(twice - sub);
      tsum  = (HW+33)'(thi_ff) + (HW+33)'(tlo_ff[63:32]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < 5; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         l2_ff    <= l2_in;
         nt_ff[0] <= in_data.no_trip;
      end
      if (rdy[1]) begin
         plo_ff   <= 64'(l2_ff[31:0]) * 64'(tott_pkg::LN2_Q32);
         phi_ff   <= (HW+32)'(l2_ff[tott_pkg::LW-1:32]) * (HW+32)'(tott_pkg::LN2_Q32);
         nt_ff[1] <= nt_ff[0];
      end
      if (rdy[2]) begin
         ln_ff    <= tott_pkg::LW'(phi_ff + (HW+32)'(plo_ff[63:32]));
         nt_ff[2] <= nt_ff[1];
      end
      if (rdy[3]) begin
         tlo_ff   <= 64'(ln_ff[31:0]) * 64'(time_constant);
         thi_ff   <= (HW+32)'(ln_ff[tott_pkg::LW-1:32]) * (HW+32)'(time_constant);
         nt_ff[3] <= nt_ff[2];
      end
      if (rdy[4]) begin
         priority if (nt_ff[3]) begin
            t_ff <= '0;
         end else if (tsum[HW+32:32] != '0) begin
            t_ff <= '1;
         end else begin
            t_ff <= tsum[31:0];
         end
         nt_ff[4] <= nt_ff[3];
      end
   end

endmodule
`default_nettype wire

[hdl/thermal_overload_trip_time_top.sv]
// ----------------------------------------------------------------------------
// thermal_overload_trip_time_top
// Thermal overload trip time, t = tau * ln(I^2 / (I^2 - (k*Ib)^2)).
// ----------------------------------------------------------------------------
// Accepts one current sample per clock while the output is not stalled and
// returns one result per sample, in order, through three front stages
// (products, exponent search, normalization), a row of 32 squaring cells
// that each produce one logarithm bit, and five back stages (combine, ln 2
// multiply, sum, tau multiply, saturate). Every stage holds its own valid
// bit, so bubbles close up while the output is stalled. When the current is
// not above k*Ib, no_trip is set and trip_time is zero.
// Registers may be written only while no sample is in flight.
`default_nettype none
module thermal_overload_trip_time_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // current
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // trip_time
   output logic [0:0]       rsp_tuser,   // no_trip
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   logic [31:0] base_ff, tau_ff;
   logic [19:0] k_ff;

   logic             cv [tott_pkg::STEPS+1];
   logic             cr [tott_pkg::STEPS+1];
   tott_pkg::lg_type cd [tott_pkg::STEPS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 32'(1) << tott_pkg::FRAC_BITS;
         k_ff    <= 20'(1) << tott_pkg::FRAC_BITS;
         tau_ff  <= 32'(1) << tott_pkg::FRAC_BITS;
      end else if (csr_valid) begin
         unique case (csr_index)
            tott_pkg::REG_BASE_CURRENT:  base_ff <= csr_data;
            tott_pkg::REG_K_FACTOR:      k_ff    <= csr_data[19:0];
            tott_pkg::REG_TIME_CONSTANT: tau_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   tott_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .current      (req_tdata),
      .base_current (base_ff),
      .k_factor     (k_ff),
      .out_valid    (cv[0]),
      .out_ready    (cr[0]),
      .out_data     (cd[0])
   );

   for (genvar g = 0; g < tott_pkg::STEPS; g++) begin : g_cell
      tott_sq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[g]),
         .in_ready  (cr[g]),
         .in_data   (cd[g]),
         .out_valid (cv[g+1]),
         .out_ready (cr[g+1]),
         .out_data  (cd[g+1])
      );
   end

   tott_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cv[tott_pkg::STEPS]),
      .in_ready      (cr[tott_pkg::STEPS]),
      .in_data       (cd[tott_pkg::STEPS]),
      .time_constant (tau_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .trip_time     (rsp_tdata),
      .no_trip       (rsp_tuser[0])
   );

endmodule
`default_nettype wire

[test/thermal_overload_trip_time_top_tb.sv]
// ----------------------------------------------------------------------------
// thermal_overload_trip_time_top_tb
// Self-checking bench for the thermal overload trip time block.
// ----------------------------------------------------------------------------
// Streams current samples through several register settings, predicts each
// trip time with a bit-exact fixed-point model and compares every result in
// order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module thermal_overload_trip_time_top_tb;

   localparam int       SETTLE      = 60;
   localparam int       CYCLE_LIMIT = 900000;
   localparam bit [1:0] REG_UNUSED  = 2'd3;

   typedef struct {
      logic [31:0] trip_time;
      logic        no_trip;
   } trip_type;

   typedef struct {
      logic [31:0] current;
      bit          typed;
      logic [31:0] trip_time;
      logic        no_trip;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // current
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // trip_time
   logic [0:0]  rsp_tuser;    // no_trip
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   logic [31:0] ib_reg;
   logic [19:0] k_reg;
   logic [31:0] tau_reg;

   trip_type    trip_queue[$];
   int          failures;
   int          cycles;
   int          sent;
   int          received;
   int          no_trip_seen;
   row_type     directed[$];

   thermal_overload_trip_time_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] mul_q32(logic [63:0] x, logic [63:0] y);
      logic [127:0] p;
      p = x * y;
      return p[95:32];
   endfunction

   function automatic logic [63:0] log2_q32(logic [63:0] x);
      int          n;
      logic [63:0] m;
      logic [63:0] sq;
      logic [63:0] frac;
      n    = 0;
      frac = '0;
      for (int i = 63; i > 0; i--) begin
         if (x[i] && n == 0) n = i;
      end
      if (n >= 31) m = x >> (n - 31);
      else m = x << (31 - n);
      for (int i = 0; i < 32; i++) begin
         sq = m * m;
         if (sq[63]) begin
            frac[31 - i] = 1'b1;
            m = sq >> 32;
         end else begin
            m = sq >> 31;
         end
      end
      return (64'(n) << 32) | frac;
   endfunction

   function automatic trip_type trip_for(logic [31:0] current);
      trip_type    r;
      logic [63:0] a, b, twice, sub, l2, t;
      a = 64'(current) << tott_pkg::FRAC_BITS;
      b = 64'(k_reg) * 64'(ib_reg);
      r.trip_time = '0;
      r.no_trip   = 1'b1;
      if (a > b) begin
         twice = 2 * log2_q32(a);
         sub   = log2_q32(a - b) + log2_q32(a + b);
         l2    = (sub >= twice) ? 64'd0 : twice - sub;
         t     = mul_q32(mul_q32(l2, 64'(tott_pkg::LN2_Q32)), 64'(tau_reg));
         r.trip_time = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
         r.no_trip   = 1'b0;
      end
      return r;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (n > 0) req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b1;
      csr_index  <= index;
      csr_data   <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         tott_pkg::REG_BASE_CURRENT:  ib_reg  = value;
         tott_pkg::REG_K_FACTOR:      k_reg   = value[19:0];
         tott_pkg::REG_TIME_CONSTANT: tau_reg = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic send_current(logic [31:0] current);
      csr_valid  <= 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= current;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      trip_queue.push_back(trip_for(current));
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (trip_queue.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic [31:0] random_current();
      logic [63:0] b;
      int          pick;
      b    = 64'(k_reg) * 64'(ib_reg);
      pick = $urandom_range(0, 9);
      if (pick < 2) return $urandom();
      if (pick < 3) return 32'(b >> tott_pkg::FRAC_BITS) + $urandom_range(0, 2) - 1;
      if (pick < 4) return $urandom_range(0, 8);
      return 32'(b >> tott_pkg::FRAC_BITS) + ($urandom() >> $urandom_range(4, 31)) + 1;
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 70 || cycles % 2000 < 300) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 9) == 0);
   end

   always @(posedge clock) begin
      trip_type exp_trip;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (trip_queue.size() == 0) begin
            $error("unexpected result trip_time %h no_trip %b", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            exp_trip = trip_queue.pop_front();
            if (rsp_tdata !== exp_trip.trip_time) begin
               $error("trip_time expected %h actual %h", exp_trip.trip_time, rsp_tdata);
               failures++;
            end
            if (rsp_tuser[0] !== exp_trip.no_trip) begin
               $error("no_trip expected %b actual %b", exp_trip.no_trip, rsp_tuser[0]);
               failures++;
            end
            if (rsp_tuser[0]) no_trip_seen++;
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      trip_type got;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      rsp_tready = 1'b0;
      cycles     = 0;
      failures   = 0;
      sent       = 0;
      received   = 0;
      no_trip_seen = 0;
      ib_reg  = 32'h0001_0000;
      k_reg   = 20'h1_0000;
      tau_reg = 32'h0001_0000;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setting: k*Ib = 1.0 A
      directed = '{
         '{32'h0000_0000, 1, 32'h0, 1'b1},
         '{32'h0001_0000, 1, 32'h0, 1'b1},
         '{32'h0000_FFFF, 1, 32'h0, 1'b1},
         '{32'h0001_0001, 0, 32'h0, 1'b0},
         '{32'h0002_0000, 0, 32'h0, 1'b0},
         '{32'hFFFF_FFFF, 0, 32'h0, 1'b0},
         '{32'h8000_0000, 0, 32'h0, 1'b0},
         '{32'h0000_0001, 1, 32'h0, 1'b1}
      };
      foreach (directed[i]) begin
         send_current(directed[i].current);
         if (directed[i].typed) begin
            got = trip_queue[$];
            if (got.trip_time !== directed[i].trip_time || got.no_trip !== directed[i].no_trip)
               begin
               $error("directed row %0d: table %h/%b predictor %h/%b", i,
                      directed[i].trip_time, directed[i].no_trip, got.trip_time, got.no_trip);
               failures++;
            end
         end
      end
      drain();

      // zero k, then zero Ib: ratio one, no trip only at zero current
      write_reg(tott_pkg::REG_K_FACTOR, 32'h0);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_current(32'h0);
      send_current(32'h1);
      send_current(32'hFFFF_FFFF);
      drain();
      write_reg(tott_pkg::REG_K_FACTOR, 32'h1_0000);
      write_reg(tott_pkg::REG_BASE_CURRENT, 32'h0);
      send_current(32'h1);
      send_current(32'h0);
      drain();

      // extremes: saturation with the largest tau and near-threshold current, then zero tau and the largest k and Ib
      write_reg(tott_pkg::REG_BASE_CURRENT, 32'h0001_0000);
      write_reg(tott_pkg::REG_TIME_CONSTANT, 32'hFFFF_FFFF);
      send_current(32'h0001_0001);
      send_current(32'h0001_0100);
      send_current(32'hFFFF_FFFF);
      drain();
      write_reg(tott_pkg::REG_TIME_CONSTANT, 32'h0);
      send_current(32'h0001_0001);
      send_current(32'h0000_8000);
      drain();
      write_reg(tott_pkg::REG_K_FACTOR, 32'hF_FFFF);
      write_reg(tott_pkg::REG_BASE_CURRENT, 32'hFFFF_FFFF);
      write_reg(tott_pkg::REG_TIME_CONSTANT, 32'h0100_0000);
      send_current(32'hFFFF_FFFF);
      send_current(32'h0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(tott_pkg::REG_BASE_CURRENT, 32'h0001_0000);
               write_reg(tott_pkg::REG_K_FACTOR, 32'h1_0000);
               write_reg(tott_pkg::REG_TIME_CONSTANT, 32'h0001_0000);
            end
            1: begin
               write_reg(tott_pkg::REG_BASE_CURRENT, $urandom_range(32'h100, 32'h0100_0000));
               write_reg(tott_pkg::REG_K_FACTOR, $urandom_range(32'h8000, 32'h3_0000));
               write_reg(tott_pkg::REG_TIME_CONSTANT, $urandom());
            end
            2: begin
               write_reg(tott_pkg::REG_BASE_CURRENT, 32'hFFFF_FFFF);
               write_reg(tott_pkg::REG_K_FACTOR, 32'h1);
               write_reg(tott_pkg::REG_TIME_CONSTANT, 32'hFFFF_FFFF);
            end
            3: begin
               write_reg(tott_pkg::REG_BASE_CURRENT, 32'h1);
               write_reg(tott_pkg::REG_K_FACTOR, 32'hF_FFFF);
               write_reg(tott_pkg::REG_TIME_CONSTANT, 32'h1);
            end
            default: begin
               write_reg(tott_pkg::REG_BASE_CURRENT, $urandom() >> $urandom_range(0, 16));
               write_reg(tott_pkg::REG_K_FACTOR, $urandom_range(0, 32'hF_FFFF));
               write_reg(tott_pkg::REG_TIME_CONSTANT, $urandom() >> $urandom_range(0, 16));
               write_reg(REG_UNUSED, $urandom());
            end
         endcase
         for (int n = 0; n < 205; n++) begin
            send_current(random_current());
            if (cycles % 1500 > 200) idle_gap();
         end
         drain();
      end

      $display("%0d samples sent, %0d results checked (%0d below threshold)",
               sent, received, no_trip_seen);
      $display("covered reset, zero, saturating and random k, Ib and tau settings");
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
hdl/tott_pkg.sv
hdl/tott_front.sv
hdl/tott_sq_cell.sv
hdl/tott_back.sv
hdl/thermal_overload_trip_time_top.sv
test/thermal_overload_trip_time_top_tb.sv
